// ===== rtl/eqjk_pkg.sv =====
// Package for the equi-join key match core: action codes, field widths and
// the probe record that walks the cell chain. No dependencies.
`default_nettype none

package eqjk_pkg;

  localparam int KEY_W        = 32;
  localparam int ACT_W        = 2;
  localparam int IDX_W        = 8;
  localparam int MAX_ROWS_DEF = 256;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PROBE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Probe record carried from cell to cell.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } probe_t;

endpackage

`default_nettype wire

// ===== rtl/eqjk_cell.sv =====
// One row of the key table: stores a single source key and compares the probe
// passing through it. Depends on eqjk_pkg.
`default_nettype none

module eqjk_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 9
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              adv,
  input  wire  [CNT_W-1:0]                 row_cnt,
  input  wire                              ld_en,
  input  wire  [eqjk_pkg::KEY_W-1:0]       ld_key,
  input  wire                              pv_in,
  input  eqjk_pkg::probe_t                 pk_in,
  output logic                             pv_out,
  output eqjk_pkg::probe_t                 pk_out
);

  localparam int IW = eqjk_pkg::IDX_W;
  localparam logic [IW-1:0]    IDX_LOW = IW'(CELL_IDX % (2 ** IW));
  localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(CELL_IDX);

  logic [eqjk_pkg::KEY_W-1:0] key_r;
  logic                       pv_r;
  eqjk_pkg::probe_t           pk_r;
  eqjk_pkg::probe_t           pk_nxt;
  logic                       live;

  // Only rows below the fill count take part.
  assign live = (IDX_CNT < row_cnt);

  always_comb begin
    pk_nxt = pk_in;
    if (!pk_in.hit && live && (key_r == pk_in.key)) begin
      pk_nxt.hit = 1'b1;
      pk_nxt.idx = IDX_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en && (row_cnt == IDX_CNT)) begin
      key_r <= ld_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= pv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pk_r <= pk_nxt;
    end
  end

  assign pv_out = pv_r;
  assign pk_out = pk_r;

endmodule

`default_nettype wire

// ===== rtl/equi_join_key_match_core.sv =====
// Top level of the equi-join key match core: fill counter, flags, result
// register and the chain of eqjk_cell rows. Depends on eqjk_pkg, eqjk_cell.
`default_nettype none

//  channel | handshake             | fields
//  --------+-----------------------+-----------------------------------------------
//  in      | in_valid / in_stall   | action, key, last
//  out     | out_valid / out_stall | found, match_index, any_missing, overflow, batch_last
//
//  Load and clear give no result.
//  A probe walks the MAX_ROWS cells one per cycle while the chain is not held;
//  in_stall is high until its result reaches the output register, and the next
//  item is taken in the following cycle at the earliest.
//  Reset (synchronous, rst_n low) empties the table and clears both flags.
//  A stalled result holds a finished probe at the chain tail; no new item is taken until it lands.

module equi_join_key_match_core #(
  parameter int MAX_ROWS = eqjk_pkg::MAX_ROWS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [eqjk_pkg::ACT_W-1:0]       in_action,
  input  wire  signed [eqjk_pkg::KEY_W-1:0] in_key,
  input  wire                              in_last,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_found,
  output logic [eqjk_pkg::IDX_W-1:0]       out_match_index,
  output logic                             out_any_missing,
  output logic                             out_overflow,
  output logic                             out_batch_last
);

  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ROWS);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             miss_r, miss_nxt;
  logic             busy_r, busy_nxt;
  logic             last_r;
  logic             oval_r, oval_nxt;
  logic             ofound_r;
  logic [eqjk_pkg::IDX_W-1:0] oidx_r;
  logic             oam_r, oovf_r, olast_r;

  logic             in_xfer, out_xfer;
  logic             is_load, is_probe, is_clear;
  logic             ld_en;
  logic             adv, land, tail_v, am;

  logic [MAX_ROWS:0]   chain_v;
  eqjk_pkg::probe_t    chain_pk [MAX_ROWS+1];

  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !busy_r;
  assign out_xfer = oval_r && !out_stall;

  assign is_load  = in_xfer && (in_action == eqjk_pkg::ACT_LOAD);
  assign is_probe = in_xfer && (in_action == eqjk_pkg::ACT_PROBE);
  assign is_clear = in_xfer && (in_action == eqjk_pkg::ACT_CLEAR);
  assign ld_en    = is_load && (cnt_r < FULL_CNT);

  assign tail_v = chain_v[MAX_ROWS];
  assign land   = tail_v && (!oval_r || !out_stall);
  // Hold the chain while the finished probe cannot leave the tail.
  assign adv    = !(tail_v && !land);
  assign am     = miss_r || !chain_pk[MAX_ROWS].hit;

  assign chain_v[0]      = is_probe;
  assign chain_pk[0].key = in_key;
  assign chain_pk[0].hit = 1'b0;
  assign chain_pk[0].idx = '0;

  for (genvar j = 0; j < MAX_ROWS; j++) begin : g_cell
    eqjk_cell #(
      .CELL_IDX(j),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .row_cnt(cnt_r),
      .ld_en  (ld_en),
      .ld_key (in_key),
      .pv_in  (chain_v[j]),
      .pk_in  (chain_pk[j]),
      .pv_out (chain_v[j+1]),
      .pk_out (chain_pk[j+1])
    );
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    miss_nxt = miss_r;
    busy_nxt = busy_r;
    oval_nxt = oval_r;
    if (out_xfer) begin
      oval_nxt = 1'b0;
    end
    if (is_load) begin
      if (ld_en) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (is_clear) begin
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
      miss_nxt = 1'b0;
    end
    if (is_probe) begin
      busy_nxt = 1'b1;
    end
    if (land) begin
      busy_nxt = 1'b0;
      oval_nxt = 1'b1;
      miss_nxt = last_r ? 1'b0 : am;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      miss_r <= 1'b0;
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      miss_r <= miss_nxt;
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_probe) begin
      last_r <= in_last;
    end
    if (land) begin
      ofound_r <= chain_pk[MAX_ROWS].hit;
      oidx_r   <= chain_pk[MAX_ROWS].hit ? chain_pk[MAX_ROWS].idx : '0;
      oam_r    <= am;
      oovf_r   <= ovf_r;
      olast_r  <= last_r;
    end
  end

  assign out_valid       = oval_r;
  assign out_found       = ofound_r;
  assign out_match_index = oidx_r;
  assign out_any_missing = oam_r;
  assign out_overflow    = oovf_r;
  assign out_batch_last  = olast_r;

  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_v[MAX_ROWS:1]) <= 1)
    else $error("more than one probe in the cell chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (chain_v[MAX_ROWS:1] == '0))
    else $error("probe in chain while input side is open");

  a_land_frees: assert property (@(posedge clk) disable iff (!rst_n)
    land |=> (!busy_r && oval_r))
    else $error("landed probe did not free the input side");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !ofound_r) |-> (oidx_r == '0 && oam_r))
    else $error("miss reported with nonzero index or clear missing flag");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("fill count beyond table size");

endmodule

`default_nettype wire
